FILE: src/gbn_pkg.sv
// Shared types and constants for the greedy box suppression block.
package gbn_pkg;

  // Default capacity of the box store.
  localparam int DefMaxBoxes = 64;

  // Reset value of the overlap threshold (about 0.7 in 1/65536 units).
  localparam logic [16:0] ThreshReset = 17'd45875;

  // One pixel in Q11.4.
  localparam logic signed [17:0] OnePixel = 18'sd16;

  // One stored box: nominal index, area and four corners.
  typedef struct packed {
    logic [5:0]         idx;
    logic [31:0]        area;
    logic signed [15:0] bottom;
    logic signed [15:0] right;
    logic signed [15:0] top;
    logic signed [15:0] left;
  } box_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_LOAD,
    ST_CHECK,
    ST_LOAD_A,
    ST_PUSH,
    ST_COMPARE,
    ST_DRAIN,
    ST_FLUSH
  } gbn_state_t;

endpackage

FILE: src/gbn_box_mem.sv
// Box store: one write port and one read port with registered read data.
module gbn_box_mem
  import gbn_pkg::*;
#(
  parameter int MAX_BOXES = DefMaxBoxes,
  parameter int AW        = 6
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  box_t          wdata,
  input  logic [AW-1:0] raddr,
  output box_t          rdata
);

  box_t mem [MAX_BOXES];

  // Synchronous write and registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: src/gbn_iou.sv
// Pipelined overlap test of the current box against one candidate box.
module gbn_iou
  import gbn_pkg::*;
#(
  parameter int AW = 6
) (
  input  logic          clk,
  input  logic          rst,
  input  box_t          box_a,
  input  box_t          box_b,
  input  logic          in_v,
  input  logic [AW-1:0] in_idx,
  input  logic [16:0]   thresh,
  output logic          busy,
  output logic          res_v,
  output logic [AW-1:0] res_idx,
  output logic          res_hit
);

  // Stage 0: intersection width and height.
  logic signed [17:0] lo_x, hi_x, lo_y, hi_y, span_x, span_y;
  logic [16:0]        w0, h0;
  logic [31:0]        ab0;
  logic [AW-1:0]      idx0;
  logic               v0;

  always_comb begin
    lo_x   = 18'(box_a.left > box_b.left ? box_a.left : box_b.left);
    hi_x   = 18'(box_a.right < box_b.right ? box_a.right : box_b.right);
    lo_y   = 18'(box_a.top > box_b.top ? box_a.top : box_b.top);
    hi_y   = 18'(box_a.bottom < box_b.bottom ? box_a.bottom : box_b.bottom);
    span_x = hi_x - lo_x + OnePixel;
    span_y = hi_y - lo_y + OnePixel;
  end

  always_ff @(posedge clk) begin
    w0   <= (span_x > 0) ? span_x[16:0] : '0;
    h0   <= (span_y > 0) ? span_y[16:0] : '0;
    ab0  <= box_b.area;
    idx0 <= in_idx;
  end

  // Stage 1: intersection area.
  logic [33:0]   inter1;
  logic [31:0]   ab1;
  logic [AW-1:0] idx1;
  logic          v1;

  always_ff @(posedge clk) begin
    inter1 <= w0 * h0;
    ab1    <= ab0;
    idx1   <= idx0;
  end

  // Stage 2: union area, signed.
  logic signed [35:0] uni2;
  logic [33:0]        inter2;
  logic [AW-1:0]      idx2;
  logic               v2;

  always_ff @(posedge clk) begin
    uni2   <= $signed({4'b0, box_a.area}) + $signed({4'b0, ab1})
              - $signed({2'b0, inter1});
    inter2 <= inter1;
    idx2   <= idx1;
  end

  // Stage 3: threshold times union, in two partial products.
  logic [33:0]   plo3;
  logic [32:0]   phi3;
  logic          pos3;
  logic [33:0]   inter3;
  logic [AW-1:0] idx3;
  logic          v3;

  always_ff @(posedge clk) begin
    plo3   <= thresh * uni2[16:0];
    phi3   <= thresh * uni2[32:17];
    pos3   <= (uni2 > 0);
    inter3 <= inter2;
    idx3   <= idx2;
  end

  // Stage 4: combine the partial products.
  logic [49:0]   prod4, lhs4;
  logic          pos4, nz4;
  logic [AW-1:0] idx4;
  logic          v4;

  always_ff @(posedge clk) begin
    prod4 <= {phi3, 17'b0} + {16'b0, plo3};
    lhs4  <= {inter3, 16'b0};
    pos4  <= pos3;
    nz4   <= (inter3 != '0);
    idx4  <= idx3;
  end

  // Stage valid bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      v0 <= in_v;
      v1 <= v0;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
  end

  // Decision: ratio test, or any overlap when the union is not positive.
  assign res_v   = v4;
  assign res_idx = idx4;
  assign res_hit = pos4 ? (lhs4 >= prod4) : nz4;
  assign busy    = v0 | v1 | v2 | v3 | v4;

endmodule

FILE: src/greedy_box_nms.sv
// Top level: load sequencer, greedy suppression sweep and output register.
//
// Boxes arrive on the input channel (in_valid / in_stall) in descending
// score order, one request per cycle while loading. The request with
// final_box set is stored and then starts the sweep; in_stall stays high
// until the last kept index has been handed to the output register.
// Boxes beyond MAX_BOXES are dropped, but their final mark still counts.
// Each kept box gives one request on the output channel (out_valid /
// out_stall) with its nominal index; the last one carries last_kept and
// the number of kept boxes in kept_total. In the sweep, the single read
// port of the box store feeds the five-stage overlap pipeline, which is
// drained before the next box is examined. A stalled output request holds;
// the sweep waits when it has a second kept index to hand over.
// The overlap threshold (wr_en / wr_data) resets to 45875 and may be
// rewritten while the block is idle. Synchronous reset empties the set.
module greedy_box_nms
  import gbn_pkg::*;
#(
  parameter int MAX_BOXES = DefMaxBoxes
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               wr_en,
  input  logic [16:0]        wr_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [5:0]         box_index,
  input  logic signed [15:0] left_x,
  input  logic signed [15:0] top_y,
  input  logic signed [15:0] right_x,
  input  logic signed [15:0] bottom_y,
  input  logic [31:0]        box_area,
  input  logic               final_box,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [5:0]         kept_index,
  output logic [6:0]         kept_total,
  output logic               last_kept
);

  localparam int AW = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
  localparam int CW = $clog2(MAX_BOXES + 1);

  gbn_state_t    state, state_next;
  logic [16:0]   thresh;
  logic [CW-1:0] count, a_ptr, b_ptr, n_set;
  logic [6:0]    keep_cnt;
  logic          flags [MAX_BOXES];
  box_t          box_a, rdata, wdata;
  logic [AW-1:0] raddr;
  logic          rd_valid;
  logic [AW-1:0] rd_idx;
  logic          pend_valid;
  logic [5:0]    pend_idx;
  logic          iou_busy, res_v, res_hit;
  logic [AW-1:0] res_idx;
  logic          in_acc, store, out_free;

  // Threshold register.
  always_ff @(posedge clk) begin
    if (rst) begin
      thresh <= ThreshReset;
    end else if (wr_en) begin
      thresh <= wr_data;
    end
  end

  assign in_stall = (state != ST_LOAD);
  assign in_acc   = in_valid && !in_stall;
  assign store    = in_acc && (count < CW'(MAX_BOXES));
  assign out_free = !out_valid || !out_stall;
  assign wdata    = '{idx: box_index, area: box_area, bottom: bottom_y,
                      right: right_x, top: top_y, left: left_x};

  // Read address: the current box while examining it, else the candidate.
  assign raddr = (state == ST_CHECK) ? a_ptr[AW-1:0] : b_ptr[AW-1:0];

  gbn_box_mem #(.MAX_BOXES(MAX_BOXES), .AW(AW)) u_mem (
    .clk   (clk),
    .we    (store),
    .waddr (count[AW-1:0]),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  gbn_iou #(.AW(AW)) u_iou (
    .clk     (clk),
    .rst     (rst),
    .box_a   (box_a),
    .box_b   (rdata),
    .in_v    (rd_valid),
    .in_idx  (rd_idx),
    .thresh  (thresh),
    .busy    (iou_busy),
    .res_v   (res_v),
    .res_idx (res_idx),
    .res_hit (res_hit)
  );

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
    end else begin
      state <= state_next;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_LOAD: begin
        if (in_acc && final_box) begin
          state_next = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (a_ptr == n_set) begin
          state_next = ST_FLUSH;
        end else if (!flags[a_ptr[AW-1:0]]) begin
          state_next = ST_LOAD_A;
        end
      end
      ST_LOAD_A: state_next = ST_PUSH;
      ST_PUSH: begin
        if (!pend_valid || out_free) begin
          state_next = ST_COMPARE;
        end
      end
      ST_COMPARE: begin
        if (b_ptr >= n_set) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!rd_valid && !iou_busy) begin
          state_next = ST_CHECK;
        end
      end
      ST_FLUSH: begin
        if (out_free) begin
          state_next = ST_LOAD;
        end
      end
      default: state_next = ST_LOAD;
    endcase
  end

  // Sweep counters, read tracking and pending kept index.
  always_ff @(posedge clk) begin
    if (rst) begin
      count      <= '0;
      a_ptr      <= '0;
      b_ptr      <= '0;
      n_set      <= '0;
      keep_cnt   <= '0;
      rd_valid   <= 1'b0;
      pend_valid <= 1'b0;
    end else begin
      case (state)
        ST_LOAD: begin
          if (store) begin
            count <= count + 1'b1;
          end
          if (in_acc && final_box) begin
            n_set    <= store ? count + 1'b1 : count;
            a_ptr    <= '0;
            keep_cnt <= '0;
          end
        end
        ST_CHECK: begin
          if (a_ptr != n_set && flags[a_ptr[AW-1:0]]) begin
            a_ptr <= a_ptr + 1'b1;
          end
        end
        ST_PUSH: begin
          if (!pend_valid || out_free) begin
            pend_valid <= 1'b1;
            pend_idx   <= box_a.idx;
            keep_cnt   <= keep_cnt + 1'b1;
            b_ptr      <= a_ptr + 1'b1;
          end
        end
        ST_COMPARE: begin
          // A read is issued while candidates remain; the last cycle clears it.
          rd_valid <= (b_ptr < n_set);
          if (b_ptr < n_set) begin
            rd_idx <= b_ptr[AW-1:0];
            b_ptr  <= b_ptr + 1'b1;
          end
        end
        ST_DRAIN: begin
          if (!rd_valid && !iou_busy) begin
            a_ptr <= a_ptr + 1'b1;
          end
        end
        ST_FLUSH: begin
          if (out_free) begin
            pend_valid <= 1'b0;
            count      <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  // Current box register, loaded from the store.
  always_ff @(posedge clk) begin
    if (state == ST_LOAD_A) begin
      box_a <= rdata;
    end
  end

  // Suppression flags: set by the overlap pipeline, cleared after a sweep.
  always_ff @(posedge clk) begin
    for (int i = 0; i < MAX_BOXES; i++) begin
      if (rst || (state == ST_FLUSH && out_free)) begin
        flags[i] <= 1'b0;
      end else if (res_v && res_hit && res_idx == AW'(i)) begin
        flags[i] <= 1'b1;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_PUSH && pend_valid && out_free) begin
      out_valid  <= 1'b1;
      kept_index <= pend_idx;
      kept_total <= '0;
      last_kept  <= 1'b0;
    end else if (state == ST_FLUSH && out_free) begin
      out_valid  <= 1'b1;
      kept_index <= pend_idx;
      kept_total <= keep_cnt;
      last_kept  <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

endmodule

FILE: src/gbn_checker.sv
// Port-level checks on the suppression block, bound to the top level.
module gbn_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_stall,
  input logic [5:0] kept_index,
  input logic [6:0] kept_total,
  input logic       last_kept
);

  // A stalled output request keeps its contents.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(kept_index)
      && $stable(kept_total) && $stable(last_kept))
    else $error("stalled output request changed");

  // The final request of a sweep reports a non-zero total.
  a_total_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && last_kept |-> kept_total != 7'd0)
    else $error("last kept box without a total");

  // Every other request reports a zero total.
  a_total_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !last_kept |-> kept_total == 7'd0)
    else $error("total shown before the last kept box");

  // Reset empties the output register.
  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output request present after reset");

endmodule

bind greedy_box_nms gbn_checker u_gbn_checker (
  .clk        (clk),
  .rst        (rst),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .kept_index (kept_index),
  .kept_total (kept_total),
  .last_kept  (last_kept)
);
